### design/uri_component_splitter_assert.svh
// Assertion macros for the URI component splitter.
// Included by the top level; needs no other file.
`ifndef URI_COMPONENT_SPLITTER_ASSERT_SVH
`define URI_COMPONENT_SPLITTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucs assertion failed");

// antecedent implies consequent in the next cycle
`define UCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucs assertion failed");

`endif

### design/ucs_pkg.sv
// Shared types, constants and helper functions of the URI component splitter.
// Used by ucs_scan, ucs_emit and uri_component_splitter; depends on nothing.
`timescale 1ns / 1ps
package ucs_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W   = 13;
  localparam int PORT_W  = 16;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [PORT_W-1:0] port_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_SCHEME, PH_C1, PH_C2, PH_AUTH, PH_LEAD, PH_PATH, PH_QUERY, PH_FRAG
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK, ST_NO_COLON, ST_EMPTY_AUTH, ST_TOO_LONG
  } status_t;

  typedef enum logic [1:0] {
    HK_NONE, HK_PLAIN, HK_IPV6
  } kind_t;

  typedef enum logic [2:0] {
    CP_SCHEME, CP_AUTHORITY, CP_USERINFO, CP_HOST,
    CP_PORT, CP_PATH, CP_QUERY, CP_FRAGMENT
  } comp_t;

  // one port colon candidate
  typedef struct packed {
    logic  found;
    pos_t  offset;
    port_t port;
    logic  stopped;
  } cand_t;

  // host scan for one choice of host start
  typedef struct packed {
    logic  closed;
    logic  opens;
    cand_t pre;
    cand_t post;
  } hyp_t;

  typedef struct packed {
    pos_t  hs;
    pos_t  he;
    pos_t  ps;
    pos_t  pe;
    port_t port;
    kind_t kind;
  } auth_t;

  typedef struct packed {
    status_t status;
    pos_t    colon;
    pos_t    as;
    pos_t    ae;
    pos_t    us;
    pos_t    ue;
    auth_t   auth;
    pos_t    pths;
    pos_t    pthe;
    pos_t    qs;
    pos_t    qe;
    pos_t    fs;
    pos_t    fe;
  } rec_t;

  function automatic cand_t cand_step(cand_t c, logic [7:0] b, pos_t p, logic take);
    cand_t r;
    r = c;
    if (!c.found) begin
      if (take && b == CH_COLON) begin
        r.found   = 1'b1;
        r.offset  = p;
        r.port    = '0;
        r.stopped = 1'b0;
      end
    end else if (!c.stopped) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        r.port = PORT_W'({c.port, 3'b000}) + PORT_W'({c.port, 1'b0})
                 + PORT_W'(b - CH_ZERO);
      end else begin
        r.stopped = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic hyp_t hyp_step(hyp_t h, logic [7:0] b, pos_t p, logic first);
    hyp_t r;
    r = h;
    if (first) begin
      r.opens = (b == CH_LBRK);
    end
    r.pre  = cand_step(h.pre, b, p, !h.closed);
    r.post = cand_step(h.post, b, p, h.closed);
    if (b == CH_RBRK) begin
      r.closed = 1'b1;
    end
    return r;
  endfunction

  function automatic auth_t finalize(hyp_t h, pos_t at, pos_t ae);
    auth_t r;
    cand_t c;
    pos_t  hs1;
    c = h.closed ? h.post : h.pre;
    r.hs = at;
    if (c.found) begin
      r.he   = c.offset;
      r.ps   = c.offset + POS_W'(1);
      r.pe   = ae;
      r.port = c.port;
    end else begin
      r.he   = ae;
      r.ps   = '0;
      r.pe   = '0;
      r.port = '0;
    end
    hs1 = r.hs + POS_W'(1);
    if (r.hs < r.he && h.opens) begin
      r.kind = HK_IPV6;
      r.he   = (r.he - POS_W'(1) < hs1) ? hs1 : r.he - POS_W'(1);
      r.hs   = hs1;
    end else if (r.hs < r.he) begin
      r.kind = HK_PLAIN;
    end else begin
      r.kind = HK_NONE;
    end
    return r;
  endfunction

endpackage

### design/ucs_scan.sv
// Byte scanner: tracks component boundaries one byte per valid cycle and
// builds the summary of a URI on its last byte. Depends on ucs_pkg.
`timescale 1ns / 1ps
module ucs_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          rec_valid,
  output ucs_pkg::rec_t rec
);
  import ucs_pkg::*;

  phase_t phase, phase_next;
  pos_t   pos, pos_next;
  logic   ovf, ovf_next, err2, err2_next, apres, apres_next;
  logic   at_seen, at_seen_next, qpres, qpres_next, fpres, fpres_next;
  pos_t   colon, colon_next, as, as_next, ae, ae_next, ue, ue_next;
  pos_t   pths, pths_next, pthe, pthe_next, qs, qs_next, qe, qe_next, fs, fs_next;
  hyp_t   h0, h0_next, h1, h1_next;
  auth_t  auth, auth_next, fin_n;
  pos_t   p, n;
  logic   full, do_lead, do_path, term, auth_end;
  logic [7:0] b;

  always_comb begin
    phase_next = phase; pos_next = pos; ovf_next = ovf; err2_next = err2;
    apres_next = apres; at_seen_next = at_seen; qpres_next = qpres;
    fpres_next = fpres; colon_next = colon; as_next = as; ae_next = ae;
    ue_next = ue; pths_next = pths; pthe_next = pthe; qs_next = qs;
    qe_next = qe; fs_next = fs; h0_next = h0; h1_next = h1; auth_next = auth;
    b = in_byte;
    p = pos;
    n = pos + POS_W'(1);
    full = (pos == POS_W'(MAX_LEN));
    do_lead = 1'b0;
    do_path = 1'b0;
    term = (b == CH_SLASH) || (b == CH_HASH) || (b == CH_QUEST);
    if (!full) begin
      pos_next = n;
      unique case (phase)
        PH_SCHEME: begin
          if (b == CH_COLON) begin
            colon_next = p;
            phase_next = PH_C1;
          end
        end
        PH_C1: begin
          if (b == CH_SLASH) phase_next = PH_C2;
          else do_lead = 1'b1;
        end
        PH_C2: begin
          if (b == CH_SLASH) begin
            phase_next   = PH_AUTH;
            as_next      = n;
            apres_next   = 1'b1;
            h0_next      = '0;
            at_seen_next = 1'b0;
          end else begin
            do_lead = 1'b1;
          end
        end
        PH_AUTH: begin
          if (term) begin
            ae_next = p;
            if (p == as) err2_next = 1'b1;
            auth_next = finalize(at_seen ? h1 : h0, at_seen ? ue + POS_W'(1) : as, p);
            do_lead = 1'b1;
          end else begin
            h0_next = hyp_step(h0, b, p, p == as);
            if (at_seen) begin
              h1_next = hyp_step(h1, b, p, p == ue + POS_W'(1));
            end else if (b == CH_AT) begin
              at_seen_next = 1'b1;
              ue_next      = p;
              h1_next      = '0;
            end
          end
        end
        PH_LEAD:  do_lead = 1'b1;
        PH_PATH:  do_path = 1'b1;
        PH_QUERY: begin
          if (b == CH_HASH) begin
            qe_next    = p;
            fpres_next = 1'b1;
            fs_next    = n;
            phase_next = PH_FRAG;
          end
        end
        PH_FRAG: ;
        default: ;
      endcase
      if (do_lead) begin
        if (b == CH_SLASH) begin
          phase_next = PH_LEAD;
        end else begin
          pths_next = p;
          do_path   = 1'b1;
        end
      end
      if (do_path) begin
        phase_next = PH_PATH;
        if (b == CH_QUEST) begin
          pthe_next  = p;
          qpres_next = 1'b1;
          qs_next    = n;
          phase_next = PH_QUERY;
        end else if (b == CH_HASH) begin
          pthe_next  = p;
          fpres_next = 1'b1;
          fs_next    = n;
          phase_next = PH_FRAG;
        end
      end
    end else begin
      ovf_next = 1'b1;
    end

    // summary as if the URI ended after this byte
    auth_end = (phase_next == PH_AUTH);
    fin_n = finalize(at_seen_next ? h1_next : h0_next,
                     at_seen_next ? ue_next + POS_W'(1) : as_next, n);
    if (ovf_next) rec.status = ST_TOO_LONG;
    else if (phase_next == PH_SCHEME) rec.status = ST_NO_COLON;
    else if (err2_next || (auth_end && as_next == n)) rec.status = ST_EMPTY_AUTH;
    else rec.status = ST_OK;
    rec.colon = colon_next;
    rec.as    = apres_next ? as_next : '0;
    rec.ae    = apres_next ? (auth_end ? n : ae_next) : '0;
    rec.us    = at_seen_next ? as_next : '0;
    rec.ue    = at_seen_next ? ue_next : '0;
    rec.auth  = apres_next ? (auth_end ? fin_n : auth_next) : '0;
    case (phase_next)
      PH_PATH: begin
        rec.pths = pths_next;
        rec.pthe = n;
      end
      PH_QUERY, PH_FRAG: begin
        rec.pths = pths_next;
        rec.pthe = pthe_next;
      end
      default: begin
        rec.pths = n;
        rec.pthe = n;
      end
    endcase
    rec.qs = qpres_next ? qs_next : '0;
    rec.qe = qpres_next ? ((phase_next == PH_QUERY) ? n : qe_next) : '0;
    rec.fs = fpres_next ? fs_next : '0;
    rec.fe = fpres_next ? n : '0;
  end

  assign rec_valid = in_valid && in_last;

  always_ff @(posedge clk) begin
    if (rst || (in_valid && in_last)) begin
      phase   <= PH_SCHEME;
      pos     <= '0;
      ovf     <= 1'b0;
      err2    <= 1'b0;
      apres   <= 1'b0;
      at_seen <= 1'b0;
      qpres   <= 1'b0;
      fpres   <= 1'b0;
    end else if (in_valid) begin
      phase   <= phase_next;
      pos     <= pos_next;
      ovf     <= ovf_next;
      err2    <= err2_next;
      apres   <= apres_next;
      at_seen <= at_seen_next;
      qpres   <= qpres_next;
      fpres   <= fpres_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      colon <= colon_next;
      as    <= as_next;
      ae    <= ae_next;
      ue    <= ue_next;
      pths  <= pths_next;
      pthe  <= pthe_next;
      qs    <= qs_next;
      qe    <= qe_next;
      fs    <= fs_next;
      h0    <= h0_next;
      h1    <= h1_next;
      auth  <= auth_next;
    end
  end

endmodule

### design/ucs_emit.sv
// Record emitter: holds one URI summary and sends its records in order.
// Depends on ucs_pkg.
`timescale 1ns / 1ps
module ucs_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          rec_valid,
  input  ucs_pkg::rec_t rec,
  output logic          free,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [55:0]   m_tdata,   // component, range_start, range_end, status,
                                   // host_kind, port_value, zero fill
  output logic          m_tlast    // final_record
);
  import ucs_pkg::*;

  logic  busy;
  comp_t idx;
  rec_t  snap;
  pos_t  rs, re;
  comp_t comp;
  logic  take;

  assign m_tvalid = busy;
  assign m_tlast  = (snap.status != ST_OK) || (idx == CP_FRAGMENT);
  assign take     = busy && m_tready;
  assign free     = !busy || (m_tready && m_tlast);

  always_comb begin
    comp = idx;
    rs   = '0;
    re   = '0;
    case (idx)
      CP_SCHEME:    begin rs = '0;            re = snap.colon;   end
      CP_AUTHORITY: begin rs = snap.as;       re = snap.ae;      end
      CP_USERINFO:  begin rs = snap.us;       re = snap.ue;      end
      CP_HOST:      begin rs = snap.auth.hs;  re = snap.auth.he; end
      CP_PORT:      begin rs = snap.auth.ps;  re = snap.auth.pe; end
      CP_PATH:      begin rs = snap.pths;     re = snap.pthe;    end
      CP_QUERY:     begin rs = snap.qs;       re = snap.qe;      end
      default:      begin rs = snap.fs;       re = snap.fe;      end
    endcase
    if (snap.status != ST_OK) begin
      m_tdata = {7'd0, 16'd0, HK_NONE, snap.status, 13'd0, 13'd0, CP_SCHEME};
    end else begin
      m_tdata = {7'd0, snap.auth.port, snap.auth.kind, snap.status, re, rs, comp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= CP_SCHEME;
    end else if (rec_valid) begin
      busy <= 1'b1;
      idx  <= CP_SCHEME;
    end else if (take) begin
      if (m_tlast) busy <= 1'b0;
      else idx <= comp_t'(idx + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid) snap <= rec;
  end

endmodule

### design/uri_component_splitter.sv
// URI component splitter, top level: input register, scanner and emitter.
// Depends on ucs_pkg, ucs_scan, ucs_emit and uri_component_splitter_assert.svh.
//
// Takes one URI byte per cycle on the slave side while s_tready is high,
// tlast on its final byte, and sends eight records (scheme .. fragment) or
// one error record on the master side, tlast on the final record. Each byte
// passes through the input register into the registered scanner; records
// are offered one at a time and held while m_tready is low. Bytes of the
// next URI are taken while records drain; only its final byte waits in the
// input register until the emitter is free. With the emitter free, the final
// byte goes from the input register through the scanner, whose summary is
// loaded into the emitter, which then offers the first record.
`timescale 1ns / 1ps
`include "uri_component_splitter_assert.svh"
module uri_component_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // component, range_start, range_end, status,
                                 // host_kind, port_value, zero fill
  output logic        m_tlast    // final_record
);
  import ucs_pkg::*;

  logic       iv, ilast, adv, free, rec_valid;
  logic [7:0] ibyte;
  rec_t       rec;

  assign adv      = iv && (!ilast || free);
  assign s_tready = !iv || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      iv <= 1'b1;
    end else if (adv) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ibyte <= s_tdata;
      ilast <= s_tlast;
    end
  end

  ucs_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (adv),
    .in_byte   (ibyte),
    .in_last   (ilast),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  ucs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (rec),
    .free      (free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  `UCS_ASSERT_IMPL(a_stall_only_on_last, clk, rst, !s_tready, iv && ilast)
  `UCS_ASSERT_IMPL(a_load_when_free, clk, rst, rec_valid, free)
  `UCS_ASSERT_IMPL(a_ok_ends_fragment, clk, rst, m_tvalid && m_tlast && m_tdata[30:29] == ST_OK, m_tdata[2:0] == CP_FRAGMENT)
  `UCS_ASSERT_IMPL(a_error_single, clk, rst, m_tvalid && m_tdata[30:29] != ST_OK, m_tlast)

endmodule
